// File: rtl/core/smm_pkg.sv
`default_nettype none

package smm_pkg;

   // Largest matrix size held in the element stores.
   localparam int MAX_DIM_DEFAULT = 8;

   // Widths fixed by the word formats.
   localparam int IDX_W   = 3;
   localparam int DIM_W   = 4;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int SUM_W   = 40;

   localparam logic [1:0] OP_LOAD_A  = 2'd0;
   localparam logic [1:0] OP_LOAD_B  = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [ELEM_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [SUM_W-1:0] product;
      logic                    last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_PUT
   } state_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic put;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic k_at_end;
      logic elem_last;
      logic sum_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/square_matrix_multiply_core.sv
`default_nettype none

// Channel   Direction  Word / data      Handshake
// req       in         req_word_type    req_valid / req_ready
// rsp       out        rsp_word_type    rsp_valid / rsp_ready
// csr       in         dim, 4 bits      csr_wr_en, no wait
//
// Load words are taken one per cycle while no compute word is in progress. A
// compute word blocks intake while the product is formed: each element issues
// n reads of both stores through the shared multiply-accumulate pipeline. A
// stalled output holds the next element in the accumulator. Reset clears
// control state and sets dim to 8; the element stores are not cleared.

module square_matrix_multiply_core
   import smm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_word_type     req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_word_type          rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [DIM_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   smm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   smm_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/core/smm_ram.sv
`default_nettype none

module smm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/smm_ctrl.sv
`default_nettype none

module smm_ctrl
   import smm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_opcode,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_opcode == OP_COMPUTE && !status.n_zero) begin
               cmd.start = 1'b1;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.k_at_end) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.sum_done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = status.elem_last ? ST_IDLE : ST_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/smm_datapath.sv
`default_nettype none

module smm_datapath
   import smm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire req_word_type     req_data,
   input  wire logic             csr_wr_en,
   input  wire logic [DIM_W-1:0] csr_wr_data,
   input  wire cmd_type          cmd,
   output status_type            status,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_word_type          rsp_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [DIM_W-1:0] MAX_N = DIM_W'(MAX_DIM);

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

   logic [DIM_W-1:0]  dim_ff;
   logic [DIM_W-1:0]  n;
   logic [IDX_W-1:0]  i_ff, j_ff, k_ff;
   logic              k_at_end;
   logic              j_at_end;
   logic              i_at_end;

   logic              load_ok;
   logic              wr_a, wr_b;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr_a, rd_addr_b;
   logic [ELEM_W-1:0] rd_a, rd_b;

   tag_type                  s1_ff, s2_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  prod_ext;
   logic signed [SUM_W-1:0]  acc_ff;
   logic                     sum_done_ff;

   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         dim_ff <= csr_wr_data;
      end
   end

   // A size above the store's limit runs as the limit.
   assign n        = (dim_ff > MAX_N) ? MAX_N : dim_ff;
   assign k_at_end = ({1'b0, k_ff} == n - 4'd1);
   assign j_at_end = ({1'b0, j_ff} == n - 4'd1);
   assign i_at_end = ({1'b0, i_ff} == n - 4'd1);

   // Element stores; loads outside the stores are dropped.
   assign load_ok = req_valid && req_ready
                    && ({1'b0, req_data.row} < MAX_N)
                    && ({1'b0, req_data.col} < MAX_N);
   assign wr_a    = load_ok && (req_data.opcode == OP_LOAD_A);
   assign wr_b    = load_ok && (req_data.opcode == OP_LOAD_B);
   assign wr_addr = AW'(int'(req_data.row) * MAX_DIM + int'(req_data.col));

   assign rd_addr_a = AW'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign rd_addr_b = AW'(int'(k_ff) * MAX_DIM + int'(j_ff));

   smm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   smm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   // Element indices: k steps per issued term, j per delivered element, i when j wraps.
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
      end else if (cmd.start) begin
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
      end else begin
         if (cmd.issue) begin
            k_ff <= k_at_end ? '0 : k_ff + 3'd1;
         end
         if (cmd.put) begin
            if (j_at_end) begin
               j_ff <= '0;
               i_ff <= i_ff + 3'd1;
            end else begin
               j_ff <= j_ff + 3'd1;
            end
         end
      end
   end

   // Multiply-accumulate pipeline: read, multiply, accumulate.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         s2_ff       <= '0;
         sum_done_ff <= 1'b0;
      end else begin
         s1_ff.valid <= cmd.issue;
         s1_ff.first <= (k_ff == '0);
         s1_ff.last  <= k_at_end;
         s2_ff       <= s1_ff;
         sum_done_ff <= s2_ff.valid && s2_ff.last;
      end
   end

   assign prod_in  = $signed(rd_a) * $signed(rd_b);
   assign prod_ext = {{(SUM_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_ff.valid) begin
         acc_ff <= s2_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   // Output register; the accumulator holds until the word is moved here.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.put) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         rsp_data_ff.out_row <= i_ff;
         rsp_data_ff.out_col <= j_ff;
         rsp_data_ff.product <= acc_ff;
         rsp_data_ff.last    <= i_at_end && j_at_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.n_zero    = (n == '0);
   assign status.k_at_end  = k_at_end;
   assign status.elem_last = i_at_end && j_at_end;
   assign status.sum_done  = sum_done_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import smm_pkg::*;

   localparam int          HALF_PERIOD   = 4;
   localparam int          RESET_CYCLES  = 4;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          STALL_LIMIT   = 4000;
   localparam int          GRID          = 8;
   localparam int          REPORT_LIMIT  = 10;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_word_type     req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_word_type     rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [DIM_W-1:0] csr_wr_data = '0;

   // Shadow copy of the block: both element stores, which entries hold data,
   // and the size register.
   logic signed [ELEM_W-1:0] a_shadow [0:GRID*GRID-1];
   logic signed [ELEM_W-1:0] b_shadow [0:GRID*GRID-1];
   bit                       a_loaded [0:GRID*GRID-1];
   bit                       b_loaded [0:GRID*GRID-1];
   logic [DIM_W-1:0]         size_shadow = DIM_RESET;

   rsp_word_type pending_products [$];
   rsp_word_type head_product;
   int           mismatches     = 0;
   int           counted_words  = 0;
   int           idle_cycles    = 0;
   int           send_idle_pct  = 0;
   int           rsp_stall_pct  = 0;

   square_matrix_multiply_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every product word is checked against the oldest predicted one.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (pending_products.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected product word: row %0d col %0d product %0d last %0b",
                        rsp_data.out_row, rsp_data.out_col, rsp_data.product,
                        rsp_data.last);
         end else begin
            head_product = pending_products.pop_front();
            if (head_product.out_row !== rsp_data.out_row ||
                head_product.out_col !== rsp_data.out_col ||
                head_product.product !== rsp_data.product ||
                head_product.last !== rsp_data.last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("product mismatch: expected row %0d col %0d product %0d last %0b,",
                           head_product.out_row, head_product.out_col,
                           head_product.product, head_product.last,
                           " got row %0d col %0d product %0d last %0b",
                           rsp_data.out_row, rsp_data.out_col, rsp_data.product,
                           rsp_data.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic int active_size();
      return (size_shadow > GRID) ? GRID : int'(size_shadow);
   endfunction

   // Work out the product matrix of the shadow stores at the current size.
   function automatic void predict_product();
      int           n;
      longint       acc;
      rsp_word_type word;
      n = active_size();
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
               acc += longint'(a_shadow[i*GRID+k]) * longint'(b_shadow[k*GRID+j]);
            word.out_row = i[IDX_W-1:0];
            word.out_col = j[IDX_W-1:0];
            word.product = acc[SUM_W-1:0];
            word.last    = (i == n - 1) && (j == n - 1);
            pending_products.push_back(word);
         end
      end
   endfunction

   function automatic void apply_word(input req_word_type w);
      int slot;
      slot = int'(w.row) * GRID + int'(w.col);
      case (w.opcode)
         OP_LOAD_A: begin
            a_shadow[slot] = w.value;
            a_loaded[slot] = 1'b1;
         end
         OP_LOAD_B: begin
            b_shadow[slot] = w.value;
            b_loaded[slot] = 1'b1;
         end
         OP_COMPUTE: predict_product();
         default: ;
      endcase
      if (w.opcode != OP_UNUSED)
         counted_words++;
   endfunction

   function automatic req_word_type make_word(input logic [1:0] op, input int r,
                                              input int c, input logic [15:0] v);
      req_word_type w;
      w.opcode = op;
      w.row    = r[IDX_W-1:0];
      w.col    = c[IDX_W-1:0];
      w.value  = v;
      return w;
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_word(input req_word_type w);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      apply_word(w);
   endtask

   // Drop valid, let every predicted product drain, then give the block time
   // to go idle after its last word.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_size(input logic [DIM_W-1:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      size_shadow = v;
   endtask

   // The stores are undefined after reset, so every element that the next
   // product reads gets loaded first.
   task automatic fill_operands();
      int n;
      n = active_size();
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < n; k++) begin
            if (!a_loaded[i*GRID+k]) send_word(make_word(OP_LOAD_A, i, k, pick_value()));
            if (!b_loaded[i*GRID+k]) send_word(make_word(OP_LOAD_B, i, k, pick_value()));
         end
      end
   endtask

   task automatic send_compute();
      fill_operands();
      send_word(make_word(OP_COMPUTE, $urandom_range(7), $urandom_range(7),
                          16'($urandom())));
   endtask

   task automatic test_reset_size();
      for (int i = 0; i < GRID; i++) begin
         for (int j = 0; j < GRID; j++) begin
            send_word(make_word(OP_LOAD_A, i, j, 16'h8000));
            send_word(make_word(OP_LOAD_B, i, j, 16'h8000));
         end
      end
      send_compute();
   endtask

   task automatic test_extreme_values();
      logic [15:0] a_vals [4] = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000};
      logic [15:0] b_vals [4] = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF};
      set_size(4'd1);
      for (int t = 0; t < 4; t++) begin
         send_word(make_word(OP_LOAD_A, 0, 0, a_vals[t]));
         send_word(make_word(OP_LOAD_B, 0, 0, b_vals[t]));
         send_compute();
      end
   endtask

   task automatic test_size_zero();
      set_size(4'd0);
      send_word(make_word(OP_LOAD_A, 7, 7, 16'h1234));
      send_compute();
   endtask

   task automatic test_size_clamp();
      set_size(4'd15);
      send_compute();
   endtask

   task automatic test_ignored_opcode();
      set_size(4'd2);
      send_word(make_word(OP_UNUSED, 0, 0, 16'hFFFF));
      send_word(make_word(OP_UNUSED, 7, 7, 16'h8000));
      send_word(make_word(OP_UNUSED, 1, 1, 16'h0000));
      send_compute();
   endtask

   task automatic test_loads_beyond_size();
      set_size(4'd2);
      send_word(make_word(OP_LOAD_A, 1, 7, 16'h7FFF));
      send_word(make_word(OP_LOAD_B, 7, 0, 16'h8000));
      send_word(make_word(OP_LOAD_A, 7, 7, 16'h0100));
      send_word(make_word(OP_LOAD_B, 7, 7, 16'hFF00));
      send_compute();
      set_size(4'd8);
      send_compute();
   endtask

   function automatic logic [DIM_W-1:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 40) return DIM_W'($urandom_range(3, 1));
      if (r < 75) return DIM_W'($urandom_range(5, 4));
      if (r < 90) return DIM_W'($urandom_range(8, 6));
      if (r < 95) return 4'd0;
      return DIM_W'($urandom_range(15, 9));
   endfunction

   // Mostly a few loads inside the active size and then a product; now and
   // then unused opcodes and loads anywhere in the store.
   task automatic send_sequence();
      int n;
      int loads;
      int lim;
      n     = active_size();
      loads = $urandom_range(6, 1);
      for (int t = 0; t < loads; t++) begin
         lim = (n == 0 || $urandom_range(9) == 0) ? GRID - 1 : n - 1;
         send_word(make_word($urandom_range(1) ? OP_LOAD_A : OP_LOAD_B,
                             $urandom_range(lim), $urandom_range(lim), pick_value()));
         if ($urandom_range(11) == 0)
            send_word(make_word(OP_UNUSED, $urandom_range(7), $urandom_range(7),
                                16'($urandom())));
      end
      if ($urandom_range(7) != 0)
         send_compute();
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
      int stop_at;
      settle();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at       = counted_words + quota;
      set_size(pick_size());
      while (counted_words < stop_at) begin
         send_sequence();
         if ($urandom_range(3) == 0)
            set_size(pick_size());
      end
   endtask

   task automatic test_random_traffic();
      run_phase(0, 0, 39);
      run_phase(84, 0, 39);
      run_phase(0, 84, 39);
      run_phase(13, 13, 39);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_size();
      test_extreme_values();
      test_size_zero();
      test_size_clamp();
      test_ignored_opcode();
      test_loads_beyond_size();
      test_random_traffic();
      settle();
      if (mismatches == 0 && pending_products.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/smm_pkg.sv
rtl/core/smm_ram.sv
rtl/core/smm_ctrl.sv
rtl/core/smm_datapath.sv
rtl/core/square_matrix_multiply_core.sv
tb/sv/tb.sv
